// ===== rtl/weekly_time_window_volume_select_top_assert.svh =====
// Assertion macros for the volume selector.
`ifndef WEEKLY_TIME_WINDOW_VOLUME_SELECT_TOP_ASSERT_SVH
`define WEEKLY_TIME_WINDOW_VOLUME_SELECT_TOP_ASSERT_SVH

// Same-cycle implication.
`define WTWVS_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WTWVS_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wtwvs_pkg.sv =====
package wtwvs_pkg;

   localparam int NUM_SLOTS_DEFAULT = 4;
   localparam int CSR_INDEX_W       = 5;
   localparam int CSR_DATA_W        = 38;
   localparam int MINUTE_W          = 11;
   localparam int MINUTES_PER_HOUR  = 60;

   localparam logic [7:0] BASE_VOLUME_RESET = 8'd70;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_VOLUME  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_IN_USE = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_BASE    = CSR_INDEX_W'(2);

   localparam logic [2:0] WDAY_SUNDAY   = 3'd0;
   localparam logic [2:0] WDAY_SATURDAY = 3'd6;
   localparam logic [2:0] WDAY_ALIAS    = 3'd7;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [2:0] weekday;
      logic       clock_valid;
   } req_type;

   typedef struct packed {
      logic [7:0] volume;
      logic       from_slot;
   } rsp_type;

   typedef struct packed {
      logic [7:0] volume;
      logic [5:0] end_minute;
      logic [4:0] end_hour;
      logic [5:0] start_minute;
      logic [4:0] start_hour;
      logic [6:0] days;
      logic       active;
   } slot_type;

   typedef struct packed {
      logic [7:0] base_volume;
      logic [2:0] slots_in_use;
   } cfg_type;

   // bit0 Monday .. bit6 Sunday; the unused weekday code counts as Sunday
   function automatic logic [6:0] day_bit(input logic [2:0] wday);
      logic [6:0] mask;
      if (wday == WDAY_SUNDAY || wday == WDAY_ALIAS) begin
         mask = 7'b100_0000;
      end else begin
         mask = 7'b000_0001 << (wday - 3'd1);
      end
      return mask;
   endfunction

   function automatic logic [2:0] prev_weekday(input logic [2:0] wday);
      logic [2:0] prev;
      if (wday == WDAY_SUNDAY || wday == WDAY_ALIAS) begin
         prev = WDAY_SATURDAY;
      end else begin
         prev = wday - 3'd1;
      end
      return prev;
   endfunction

   function automatic logic [MINUTE_W-1:0] day_minutes(input logic [4:0] hour,
                                                       input logic [5:0] minute);
      return MINUTE_W'(MINUTE_W'(hour) * MINUTE_W'(MINUTES_PER_HOUR))
             + MINUTE_W'(minute);
   endfunction

endpackage

// ===== rtl/wtwvs_csr.sv =====
module wtwvs_csr
   import wtwvs_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg,
   output slot_type               slots [NUM_SLOTS]
);

   cfg_type  cfg_ff;
   slot_type slot_ff [NUM_SLOTS];
   logic     write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_volume  <= BASE_VOLUME_RESET;
         cfg_ff.slots_in_use <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (write) begin
         priority if (csr_index == CSR_BASE_VOLUME) begin
            cfg_ff.base_volume <= csr_data[7:0];
         end else if (csr_index == CSR_SLOTS_IN_USE) begin
            cfg_ff.slots_in_use <= csr_data[2:0];
         end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (csr_index == CSR_SLOT_BASE + CSR_INDEX_W'(i)) begin
                  slot_ff[i] <= slot_type'(csr_data);
               end
            end
         end
      end
   end

   assign cfg   = cfg_ff;
   assign slots = slot_ff;

endmodule

// ===== rtl/wtwvs_slot_match.sv =====
module wtwvs_slot_match
   import wtwvs_pkg::*;
(
   input  slot_type            slot,
   input  logic                enable,
   input  logic [MINUTE_W-1:0] now_min,
   input  logic [6:0]          today,
   input  logic [6:0]          yesterday,
   output logic                hit
);

   logic [MINUTE_W-1:0] start_min;
   logic [MINUTE_W-1:0] end_min;
   logic                today_on;
   logic                prev_on;
   logic                in_window;

   assign start_min = day_minutes(slot.start_hour, slot.start_minute);
   assign end_min   = day_minutes(slot.end_hour, slot.end_minute);
   assign today_on  = |(slot.days & today);
   assign prev_on   = |(slot.days & yesterday);

   // wrapped window: before the start belongs to the previous day
   always_comb begin
      priority if (start_min <= end_min) begin
         in_window = today_on && now_min >= start_min && now_min < end_min;
      end else if (now_min >= start_min) begin
         in_window = today_on;
      end else begin
         in_window = prev_on;
      end
   end

   assign hit = enable && slot.active && in_window;

endmodule

// ===== rtl/weekly_time_window_volume_select_top.sv =====
// Weekly time-window volume selector.
// req channel: one transfer carries hour, minute, weekday (0 = Sunday) and a
//    clock_valid flag. rsp channel: one transfer per request with the volume
//    and from_slot (1 when a schedule slot matched, 0 for the default volume).
// csr channel: register writes, index 0 default volume, 1 slots in use,
//    2 and up one packed slot each. Always ready; write only while idle.
// Path: a request is held in the request register, its result in the result
//    register. Throughput: one request per cycle unless rsp stalls; all slot
//    windows are compared in parallel in the stage between the two registers,
//    followed by a lowest-slot-first priority pick.
// Stall: while rsp_valid is high and rsp_ready low, the result holds and
//    one more request is still taken into the request register; req_ready
//    drops only when both registers are full.
// Reset: synchronous, clears both pipeline valids, default volume to 70,
//    slot count and all slots to zero.
`include "weekly_time_window_volume_select_top_assert.svh"

module weekly_time_window_volume_select_top
   import wtwvs_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type             cfg;
   slot_type            slots [NUM_SLOTS];

   logic                query_valid_ff, query_valid_in;
   req_type             query_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                query_adv;
   logic                rsp_free;

   logic [MINUTE_W-1:0] now_min;
   logic [6:0]          today;
   logic [6:0]          yesterday;
   logic [NUM_SLOTS-1:0] hit;

   wtwvs_csr #(.NUM_SLOTS(NUM_SLOTS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .slots     (slots)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign query_adv = query_valid_ff && rsp_free;
   assign req_ready = !query_valid_ff || rsp_free;

   assign query_valid_in = req_ready ? req_valid : query_valid_ff;
   assign rsp_valid_in   = rsp_free ? query_valid_ff : rsp_valid_ff;

   assign now_min   = day_minutes(query_ff.hour, query_ff.minute);
   assign today     = day_bit(query_ff.weekday);
   assign yesterday = day_bit(prev_weekday(query_ff.weekday));

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
      wtwvs_slot_match u_match (
         .slot      (slots[g]),
         .enable    (g < int'(cfg.slots_in_use)),
         .now_min   (now_min),
         .today     (today),
         .yesterday (yesterday),
         .hit       (hit[g])
      );
   end

   // lowest slot wins
   always_comb begin
      rsp_in.volume    = cfg.base_volume;
      rsp_in.from_slot = 1'b0;
      if (query_ff.clock_valid) begin
         for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (hit[i]) begin
               rsp_in.volume    = slots[i].volume;
               rsp_in.from_slot = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         query_valid_ff <= query_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         query_ff <= req_data;
      end
      if (query_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `WTWVS_ASSERT_IMP(a_ready_only_when_full, !req_ready, query_valid_ff && rsp_valid_ff,
      "request refused while a pipeline register is free")
   `WTWVS_ASSERT_NXT(a_query_holds, query_valid_ff && !query_adv,
      query_valid_ff && $stable(query_ff), "stalled request register changed")
   `WTWVS_ASSERT_NXT(a_invalid_clock_default, query_adv && !query_ff.clock_valid,
      !rsp_ff.from_slot && rsp_ff.volume == $past(cfg.base_volume),
      "unsynchronized clock did not give the default volume")

endmodule
